// ----- rtl/pol_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ordered list.
`timescale 1ns / 1ps

package pol_pkg;

   // Default list depth
   localparam int DEFAULT_CAPACITY = 128;

   // Field widths of the request and response channels
   localparam int OP_W    = 3;
   localparam int POS_W   = 8;
   localparam int KEY_W   = 31;
   localparam int PRICE_W = 32;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the request and set up the walk index
      logic rd;     // issue a memory read at the walk address
      logic step;   // shift one entry or compare one key, then advance unless a match was found
      logic fin;    // commit the operation and load the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic err;        // request rejected by a range or fill check
      logic is_loop;    // insert, delete or search: walks the list
      logic is_read;    // read entry
      logic more_now;   // walk has an entry left at the current index
      logic more_next;  // walk has an entry left after the next advance
      logic match;      // search key equals the entry just read
      logic rsp_free;   // response register can take a new result
   } sts_type;

endpackage

// ----- rtl/pol_ctrl.sv -----
// Sequencing state machine for the ordered list operations.
`timescale 1ns / 1ps

module pol_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pol_pkg::sts_type  sts,
   output pol_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_RD    = 5'b00100,
      S_WR    = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Drive commands from the current state
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      cmd.load  = (state_ff == S_IDLE) && req_valid;
      cmd.rd    = (state_ff == S_RD);
      cmd.step  = (state_ff == S_WR);
      cmd.fin   = (state_ff == S_FIN) && sts.rsp_free;
   end

   // Choose the next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.err) state_in = S_FIN;
            else if (sts.is_loop) state_in = sts.more_now ? S_RD : S_FIN;
            else if (sts.is_read) state_in = S_RD;
            else state_in = S_FIN;
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            if (sts.is_read || sts.match) state_in = S_FIN;
            else state_in = sts.more_next ? S_RD : S_FIN;
         end
         S_FIN: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/pol_datapath.sv -----
// Entry memories, fill count, walk index and response register of the ordered list.
`timescale 1ns / 1ps

module pol_datapath #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pol_pkg::cmd_type                 cmd,
   output pol_pkg::sts_type                 sts,
   input  logic [pol_pkg::OP_W-1:0]         req_operation,
   input  logic [pol_pkg::POS_W-1:0]        req_position,
   input  logic [pol_pkg::KEY_W-1:0]        req_key_value,
   input  logic [pol_pkg::PRICE_W-1:0]      req_price_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pol_pkg::STAT_W-1:0]       rsp_status,
   output logic [pol_pkg::POS_W-1:0]        rsp_found_position,
   output logic [pol_pkg::KEY_W-1:0]        rsp_entry_key,
   output logic [pol_pkg::PRICE_W-1:0]      rsp_entry_price,
   output logic [pol_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMPW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

   // Entry storage
   logic [pol_pkg::KEY_W-1:0]   key_store_ff   [CAPACITY];
   logic [pol_pkg::PRICE_W-1:0] price_store_ff [CAPACITY];

   // Captured request
   logic [pol_pkg::OP_W-1:0]    op_ff;
   logic [pol_pkg::POS_W-1:0]   pos_ff;
   logic [pol_pkg::KEY_W-1:0]   key_ff;
   logic [pol_pkg::PRICE_W-1:0] price_ff;

   // Walk state
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic                        found_ff, found_in;
   logic [CW-1:0]               found_pos_ff, found_pos_in;
   logic [pol_pkg::KEY_W-1:0]   rd_key_ff;
   logic [pol_pkg::PRICE_W-1:0] rd_price_ff;

   // Response register
   logic                        rsp_valid_ff;
   logic [pol_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pol_pkg::POS_W-1:0]   rsp_found_ff;
   logic [pol_pkg::KEY_W-1:0]   rsp_key_ff;
   logic [pol_pkg::PRICE_W-1:0] rsp_price_ff;
   logic [pol_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [CMPW-1:0]             pos_w, cnt_w, idx_w, step_w;
   logic [CW-1:0]               idx_dec, idx_step;
   logic                        is_ins, is_del, is_srch, is_upd, is_rd;
   logic                        pos_bad, ins_full, ins_bad, del_empty, err;
   logic                        match;
   logic [AW-1:0]               rd_addr, wr_addr;
   logic                        key_we, price_we;
   logic [pol_pkg::KEY_W-1:0]   wr_key;
   logic [pol_pkg::PRICE_W-1:0] wr_price;
   logic                        read_ok;

   // Decode the captured operation and check ranges
   always_comb begin
      is_ins    = (op_ff == pol_pkg::OP_INSERT);
      is_del    = (op_ff == pol_pkg::OP_DELETE);
      is_srch   = (op_ff == pol_pkg::OP_SEARCH);
      is_upd    = (op_ff == pol_pkg::OP_UPDATE);
      is_rd     = (op_ff == pol_pkg::OP_READ);
      pos_w     = CMPW'(pos_ff);
      cnt_w     = CMPW'(count_ff);
      pos_bad   = (pos_ff == '0) || (pos_w > cnt_w);
      ins_full  = (cnt_w == CMPW'(CAPACITY));
      ins_bad   = (pos_ff == '0) || (pos_w > cnt_w + CMPW'(1));
      del_empty = (count_ff == '0);
      case (op_ff)
         pol_pkg::OP_INSERT: err = ins_full || ins_bad;
         pol_pkg::OP_DELETE: err = del_empty || pos_bad;
         pol_pkg::OP_UPDATE: err = pos_bad;
         pol_pkg::OP_READ:   err = pos_bad;
         default:            err = 1'b0;
      endcase
   end

   // Walk index arithmetic: insert walks down, delete and search walk up
   always_comb begin
      idx_dec  = idx_ff - CW'(1);
      idx_step = is_ins ? idx_dec : idx_ff + CW'(1);
      idx_w    = CMPW'(idx_ff);
      step_w   = CMPW'(idx_step);
      rd_addr  = is_ins ? AW'(idx_dec) : AW'(idx_ff);
      match    = is_srch && (rd_key_ff == key_ff);
   end

   // Report status to the controller
   always_comb begin
      sts.err       = err;
      sts.is_loop   = is_ins || is_del || is_srch;
      sts.is_read   = is_rd;
      sts.more_now  = is_ins ? (idx_w >= pos_w) : (idx_w < cnt_w);
      sts.more_next = is_ins ? (step_w >= pos_w) : (step_w < cnt_w);
      sts.match     = match;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Select the memory write: a shift step, the new entry, or a price rewrite
   always_comb begin
      wr_addr  = AW'(idx_ff);
      wr_key   = key_ff;
      wr_price = price_ff;
      key_we   = 1'b0;
      price_we = 1'b0;
      if (cmd.step && (is_ins || is_del)) begin
         wr_addr  = is_ins ? AW'(idx_ff) : AW'(idx_dec);
         wr_key   = rd_key_ff;
         wr_price = rd_price_ff;
         key_we   = 1'b1;
         price_we = 1'b1;
      end else if (cmd.fin && !err) begin
         key_we   = is_ins;
         price_we = is_ins || is_upd;
      end
   end

   // Write and read the entry memories
   always_ff @(posedge clock) begin
      if (key_we) key_store_ff[wr_addr] <= wr_key;
      if (price_we) price_store_ff[wr_addr] <= wr_price;
      if (cmd.rd) begin
         rd_key_ff   <= key_store_ff[rd_addr];
         rd_price_ff <= price_store_ff[rd_addr];
      end
   end

   // Set up and advance the walk
   always_comb begin
      idx_in       = idx_ff;
      found_in     = found_ff;
      found_pos_in = found_pos_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         case (req_operation)
            pol_pkg::OP_INSERT: idx_in = count_ff;
            pol_pkg::OP_DELETE: idx_in = CW'(req_position);
            pol_pkg::OP_SEARCH: idx_in = '0;
            default:            idx_in = CW'(req_position) - CW'(1);
         endcase
      end else if (cmd.step) begin
         if (match) begin
            found_in     = 1'b1;
            found_pos_in = idx_ff + CW'(1);
         end else begin
            idx_in = idx_step;
         end
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         pos_ff   <= req_position;
         key_ff   <= req_key_value;
         price_ff <= req_price_value;
      end
      idx_ff       <= idx_in;
      found_pos_ff <= found_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) found_ff <= 1'b0;
      else found_ff <= found_in;
   end

   // Work out the result and the new fill count
   always_comb begin
      case (op_ff)
         pol_pkg::OP_INSERT:
            rsp_status_in = ins_full ? pol_pkg::ST_FULL :
                            ins_bad  ? pol_pkg::ST_BADPOS : pol_pkg::ST_OK;
         pol_pkg::OP_DELETE:
            rsp_status_in = del_empty ? pol_pkg::ST_EMPTY :
                            pos_bad   ? pol_pkg::ST_BADPOS : pol_pkg::ST_OK;
         pol_pkg::OP_SEARCH:
            rsp_status_in = found_ff ? pol_pkg::ST_OK : pol_pkg::ST_NOTFOUND;
         pol_pkg::OP_UPDATE, pol_pkg::OP_READ:
            rsp_status_in = pos_bad ? pol_pkg::ST_BADPOS : pol_pkg::ST_OK;
         default:
            rsp_status_in = pol_pkg::ST_OK;
      endcase
      count_in = count_ff;
      if (!err && is_ins) count_in = count_ff + CW'(1);
      if (!err && is_del) count_in = count_ff - CW'(1);
      read_ok = is_rd && !err;
   end

   // Commit the fill count and hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fin) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= found_ff ? pol_pkg::POS_W'(found_pos_ff) : '0;
         rsp_key_ff    <= read_ok ? rd_key_ff : '0;
         rsp_price_ff  <= read_ok ? rd_price_ff : '0;
         rsp_count_ff  <= pol_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_key      = rsp_key_ff;
   assign rsp_entry_price    = rsp_price_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // Fill count never passes the list depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(CAPACITY))
      else $error("fill count beyond capacity");

   // A result is committed only when the response register is free
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   // An accepted insert grows the list by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.fin && is_ins && !err) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the list");

   // Read data is consumed in the cycle after the read
   a_rd_step: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> cmd.step)
      else $error("read not followed by a step");

   // A match is only ever recorded by a search
   a_found_srch: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> is_srch)
      else $error("match flag outside a search");

endmodule

// ----- rtl/positional_ordered_list_core.sv -----
// Top level of the positional ordered list: controller plus datapath.
//
// Usage: a packed list of up to CAPACITY entries, each a 31-bit key and a
// 32-bit price in hundredths. One request on the req_ channel (valid/ready)
// carries an operation (insert, delete, search, update, read), a 1-based
// position, a key and a price. Each request yields exactly one response on
// the rsp_ channel with a status, the found position, the entry read and
// the entry count after the operation.
// Timing: one request at a time; a request walks k entries, where k is the
// number of entries shifted (insert, delete) or compared (search), or 1
// for read; k is at most CAPACITY. The walk is paced by the single-port
// entry memory: each shifted or compared entry takes a read state (S_RD)
// and then a write or compare state (S_WR).
// Reset: synchronous, active high; empties the list (count zero) and drops
// any pending response. Entry memory contents are not cleared.
// Stalls: the response sits in an output register; the next request is
// accepted and worked on while it waits, and the block holds before
// committing that next result until the earlier one has been taken.
`timescale 1ns / 1ps

module positional_ordered_list_core #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pol_pkg::OP_W-1:0]         req_operation,
   input  logic [pol_pkg::POS_W-1:0]        req_position,
   input  logic [pol_pkg::KEY_W-1:0]        req_key_value,
   input  logic [pol_pkg::PRICE_W-1:0]      req_price_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pol_pkg::STAT_W-1:0]       rsp_status,
   output logic [pol_pkg::POS_W-1:0]        rsp_found_position,
   output logic [pol_pkg::KEY_W-1:0]        rsp_entry_key,
   output logic [pol_pkg::PRICE_W-1:0]      rsp_entry_price,
   output logic [pol_pkg::COUNT_W-1:0]      rsp_entry_count
);

   pol_pkg::cmd_type cmd;
   pol_pkg::sts_type sts;

   // Sequence each request
   pol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the list and build the response
   pol_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_key_value      (req_key_value),
      .req_price_value    (req_price_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_price    (rsp_entry_price),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

// ----- dv/ordered_list_shadow.sv -----
// Shadow model of the positional ordered list: predicts each response and compares it.
`timescale 1ns / 1ps

module ordered_list_shadow #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [pol_pkg::OP_W-1:0]    req_operation,
   input  logic [pol_pkg::POS_W-1:0]   req_position,
   input  logic [pol_pkg::KEY_W-1:0]   req_key_value,
   input  logic [pol_pkg::PRICE_W-1:0] req_price_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [pol_pkg::STAT_W-1:0]  rsp_status,
   input  logic [pol_pkg::POS_W-1:0]   rsp_found_position,
   input  logic [pol_pkg::KEY_W-1:0]   rsp_entry_key,
   input  logic [pol_pkg::PRICE_W-1:0] rsp_entry_price,
   input  logic [pol_pkg::COUNT_W-1:0] rsp_entry_count,
   output int                          mismatch_count,
   output int                          outstanding,
   output int                          model_fill
);

   typedef struct packed {
      logic [pol_pkg::STAT_W-1:0]  status;
      logic [pol_pkg::POS_W-1:0]   found_position;
      logic [pol_pkg::KEY_W-1:0]   entry_key;
      logic [pol_pkg::PRICE_W-1:0] entry_price;
      logic [pol_pkg::COUNT_W-1:0] entry_count;
   } list_result_type;

   logic [pol_pkg::KEY_W-1:0]   shadow_key   [CAPACITY];
   logic [pol_pkg::PRICE_W-1:0] shadow_price [CAPACITY];
   int                          shadow_fill = 0;
   int                          errors = 0;
   list_result_type             expected_results [$];
   list_result_type             oldest;

   // Apply one request to the shadow list and return the response it must give
   function automatic list_result_type apply_request(
         input logic [pol_pkg::OP_W-1:0]    op,
         input logic [pol_pkg::POS_W-1:0]   pos,
         input logic [pol_pkg::KEY_W-1:0]   key,
         input logic [pol_pkg::PRICE_W-1:0] price);
      list_result_type res;
      int              p;
      int              i;
      res = '0;
      p   = int'(pos);
      case (op)
         pol_pkg::OP_INSERT: begin
            // full is checked ahead of the position range
            if (shadow_fill >= CAPACITY) begin
               res.status = pol_pkg::ST_FULL;
            end else if (p == 0 || p > shadow_fill + 1) begin
               res.status = pol_pkg::ST_BADPOS;
            end else begin
               for (i = shadow_fill; i >= p; i--) begin
                  shadow_key[i]   = shadow_key[i-1];
                  shadow_price[i] = shadow_price[i-1];
               end
               shadow_key[p-1]   = key;
               shadow_price[p-1] = price;
               shadow_fill++;
            end
         end
         pol_pkg::OP_DELETE: begin
            if (shadow_fill == 0) begin
               res.status = pol_pkg::ST_EMPTY;
            end else if (p == 0 || p > shadow_fill) begin
               res.status = pol_pkg::ST_BADPOS;
            end else begin
               shadow_fill--;
               for (i = p - 1; i < shadow_fill; i++) begin
                  shadow_key[i]   = shadow_key[i+1];
                  shadow_price[i] = shadow_price[i+1];
               end
            end
         end
         pol_pkg::OP_SEARCH: begin
            // first match wins
            res.status = pol_pkg::ST_NOTFOUND;
            for (i = 0; i < shadow_fill; i++) begin
               if (res.status == pol_pkg::ST_NOTFOUND && shadow_key[i] == key) begin
                  res.status         = pol_pkg::ST_OK;
                  res.found_position = pol_pkg::POS_W'(i + 1);
               end
            end
         end
         pol_pkg::OP_UPDATE: begin
            if (p == 0 || p > shadow_fill) begin
               res.status = pol_pkg::ST_BADPOS;
            end else begin
               shadow_price[p-1] = price;
            end
         end
         pol_pkg::OP_READ: begin
            if (p == 0 || p > shadow_fill) begin
               res.status = pol_pkg::ST_BADPOS;
            end else begin
               res.entry_key   = shadow_key[p-1];
               res.entry_price = shadow_price[p-1];
            end
         end
         default: begin
            // spare codes leave the list alone and answer ok
         end
      endcase
      res.entry_count = pol_pkg::COUNT_W'(shadow_fill);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // Compare responses first, then record the request taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("status", 32'(oldest.status), 32'(rsp_status));
               check_field("found_position", 32'(oldest.found_position),
                           32'(rsp_found_position));
               check_field("entry_key", 32'(oldest.entry_key), 32'(rsp_entry_key));
               check_field("entry_price", oldest.entry_price, rsp_entry_price);
               check_field("entry_count", 32'(oldest.entry_count), 32'(rsp_entry_count));
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_request(req_operation, req_position,
                                                     req_key_value, req_price_value));
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_results.size();
      model_fill     <= shadow_fill;
   end

endmodule

// ----- dv/tb_positional_ordered_list_core.sv -----
// Testbench top for the positional ordered list: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_ordered_list_core;

   localparam int CAPACITY       = pol_pkg::DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS   = 400;
   localparam int WORST_LATENCY  = 2 * CAPACITY + 3;
   localparam int DRAIN_CYCLES   = WORST_LATENCY + 8;
   localparam int WATCHDOG_LIMIT = 8 * WORST_LATENCY + 200;
   localparam int IDLE_PERCENT   = 12;
   localparam int FULL_DWELL     = 12;
   localparam int POOL_SIZE      = 16;
   localparam int POS_TOP        = (1 << pol_pkg::POS_W) - 1;
   localparam int STEADY_FIRST   = 60;
   localparam int STEADY_LAST    = 140;

   localparam logic [pol_pkg::OP_W-1:0]    OP_SPARE_FIRST = 3'd5;
   localparam logic [pol_pkg::OP_W-1:0]    OP_SPARE_MID   = 3'd6;
   localparam logic [pol_pkg::OP_W-1:0]    OP_SPARE_LAST  = 3'd7;
   localparam logic [pol_pkg::POS_W-1:0]   POS_MAX        = '1;
   localparam logic [pol_pkg::KEY_W-1:0]   KEY_MAX        = '1;
   localparam logic [pol_pkg::PRICE_W-1:0] PRICE_MAX      = '1;

   typedef enum logic [1:0] {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} load_phase_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [pol_pkg::OP_W-1:0]     req_operation = '0;
   logic [pol_pkg::POS_W-1:0]    req_position = '0;
   logic [pol_pkg::KEY_W-1:0]    req_key_value = '0;
   logic [pol_pkg::PRICE_W-1:0]  req_price_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [pol_pkg::STAT_W-1:0]   rsp_status;
   logic [pol_pkg::POS_W-1:0]    rsp_found_position;
   logic [pol_pkg::KEY_W-1:0]    rsp_entry_key;
   logic [pol_pkg::PRICE_W-1:0]  rsp_entry_price;
   logic [pol_pkg::COUNT_W-1:0]  rsp_entry_count;
   logic                         steady = 1'b0;
   int                           mismatch_count;
   int                           outstanding;
   int                           model_fill;
   int                           idle_cycles = 0;
   logic [pol_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];

   positional_ordered_list_core #(.CAPACITY(CAPACITY)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_key_value      (req_key_value),
      .req_price_value    (req_price_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_price    (rsp_entry_price),
      .rsp_entry_count    (rsp_entry_count)
   );

   ordered_list_shadow #(.CAPACITY(CAPACITY)) shadow_list (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_key_value      (req_key_value),
      .req_price_value    (req_price_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_price    (rsp_entry_price),
      .rsp_entry_count    (rsp_entry_count),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .model_fill         (model_fill)
   );

   always #5 clock = ~clock;

   // Stall the response side at random, except in the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one request, idling first at random, and hold it until taken
   task automatic send_request(input logic [pol_pkg::OP_W-1:0]    op,
                               input logic [pol_pkg::POS_W-1:0]   pos,
                               input logic [pol_pkg::KEY_W-1:0]   key,
                               input logic [pol_pkg::PRICE_W-1:0] price);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_position    <= pos;
      req_key_value   <= key;
      req_price_value <= price;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Pick one of the unused operation codes
   function automatic logic [pol_pkg::OP_W-1:0] spare_operation();
      return pol_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   // Map a percentage roll onto an operation by cumulative weights
   function automatic logic [pol_pkg::OP_W-1:0] pick_operation(input int roll, input int ins,
                                                               input int del, input int srch,
                                                               input int upd, input int rd);
      if (roll < ins)  return pol_pkg::OP_INSERT;
      if (roll < del)  return pol_pkg::OP_DELETE;
      if (roll < srch) return pol_pkg::OP_SEARCH;
      if (roll < upd)  return pol_pkg::OP_UPDATE;
      if (roll < rd)   return pol_pkg::OP_READ;
      return spare_operation();
   endfunction

   // Build one random request shaped by the current load phase
   task automatic random_request(input load_phase_type phase);
      int                          roll;
      int                          hi;
      logic [pol_pkg::OP_W-1:0]    op;
      logic [pol_pkg::POS_W-1:0]   pos;
      logic [pol_pkg::KEY_W-1:0]   key;
      logic [pol_pkg::PRICE_W-1:0] price;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW:   op = pick_operation(roll, 85, 88, 93, 96, 99);
         PHASE_SHRINK: op = pick_operation(roll, 5, 90, 94, 96, 99);
         default:      op = pick_operation(roll, 30, 55, 73, 85, 97);
      endcase
      // mostly in range, with some zero and some anywhere in the byte
      hi   = (op == pol_pkg::OP_INSERT) ? model_fill + 1 :
             ((model_fill > 0) ? model_fill : 1);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         pos = '0;
      end else if (roll < 12) begin
         pos = pol_pkg::POS_W'($urandom_range(0, POS_TOP));
      end else begin
         pos = pol_pkg::POS_W'($urandom_range(1, hi));
      end
      // pooled keys give search hits and duplicates
      if ($urandom_range(0, 1) != 0) begin
         key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         key = pol_pkg::KEY_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         price = '0;
      end else if (roll < 16) begin
         price = PRICE_MAX;
      end else begin
         price = $urandom;
      end
      send_request(op, pos, key, price);
   endtask

   // Walk the empty, reject and edge cases, build and trim a short list, then offer the spare codes
   task automatic run_directed();
      send_request(pol_pkg::OP_READ,   8'd1, '0, '0);
      send_request(pol_pkg::OP_UPDATE, 8'd1, '0, PRICE_MAX);
      send_request(pol_pkg::OP_DELETE, 8'd1, '0, '0);
      send_request(pol_pkg::OP_SEARCH, 8'd0, '0, '0);
      send_request(pol_pkg::OP_INSERT, 8'd0, KEY_MAX, PRICE_MAX);
      send_request(pol_pkg::OP_INSERT, 8'd2, KEY_MAX, PRICE_MAX);
      send_request(pol_pkg::OP_INSERT, 8'd1, KEY_MAX, PRICE_MAX);
      send_request(pol_pkg::OP_INSERT, 8'd2, '0, '0);
      send_request(pol_pkg::OP_INSERT, 8'd2, 31'd12345, 32'd100);
      send_request(pol_pkg::OP_INSERT, 8'd1, 31'd5, 32'd250);
      send_request(pol_pkg::OP_READ,   8'd1, '0, '0);
      send_request(pol_pkg::OP_READ,   8'd2, '0, '0);
      send_request(pol_pkg::OP_READ,   8'd3, '0, '0);
      send_request(pol_pkg::OP_READ,   8'd4, '0, '0);
      send_request(pol_pkg::OP_SEARCH, 8'd0, KEY_MAX, '0);
      send_request(pol_pkg::OP_SEARCH, 8'd0, '0, '0);
      send_request(pol_pkg::OP_SEARCH, 8'd0, 31'd999, '0);
      send_request(pol_pkg::OP_UPDATE, 8'd3, '0, PRICE_MAX);
      send_request(pol_pkg::OP_UPDATE, 8'd5, '0, 32'd1);
      send_request(pol_pkg::OP_READ,   POS_MAX, '0, '0);
      send_request(pol_pkg::OP_DELETE, 8'd0, '0, '0);
      send_request(pol_pkg::OP_DELETE, 8'd5, '0, '0);
      send_request(pol_pkg::OP_DELETE, 8'd2, '0, '0);
      send_request(pol_pkg::OP_DELETE, 8'd3, '0, '0);
      send_request(OP_SPARE_FIRST, POS_MAX, KEY_MAX, PRICE_MAX);
      send_request(OP_SPARE_MID, POS_MAX, KEY_MAX, PRICE_MAX);
      send_request(OP_SPARE_LAST, POS_MAX, KEY_MAX, PRICE_MAX);
   endtask

   initial begin
      load_phase_type phase;
      int             dwell;
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = pol_pkg::KEY_W'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Fill to capacity, hold there, drain to empty, then mix
      phase = PHASE_GROW;
      dwell = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
         random_request(phase);
         if (phase == PHASE_GROW && model_fill >= CAPACITY) dwell++;
         if (phase == PHASE_SHRINK && model_fill == 0) dwell++;
         if (dwell >= FULL_DWELL) begin
            phase = (phase == PHASE_GROW) ? PHASE_SHRINK : PHASE_MIXED;
            dwell = 0;
         end
      end
      req_valid <= 1'b0;

      // Wait out every outstanding response, then a quiet tail
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pol_pkg.sv
rtl/pol_ctrl.sv
rtl/pol_datapath.sv
rtl/positional_ordered_list_core.sv
dv/ordered_list_shadow.sv
dv/tb_positional_ordered_list_core.sv
